FILE: rtl/core/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared widths, register map, reset values and controller/datapath
// command and status types for the frame rate window meter.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

  // Payload field widths
  localparam int TS_W   = 63;
  localparam int IV_W   = 32;
  localparam int RATE_W = 40;
  localparam int EVT_W  = 11;
  localparam int FRAC_W = 8;

  // Configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int IDX_W  = ADDR_W - 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TICK_FREQ = '0;

  // Reset and default values
  localparam logic [DATA_W-1:0] FREQ_RESET     = 32'd1000000;
  localparam int                WINDOW_DEFAULT = 100;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch timestamp, advance event count
    logic diff;      // form interval and numerator
    logic sum;       // update ring, sum, pointer; arm divider
    logic div_step;  // one quotient bit
    logic load_out;  // move finished result into output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;  // current divider step is the last one
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/frm_if.sv
// ----------------------------------------------------------------------------
// frm_in_if / frm_out_if
// Valid/ready channels carrying frame timestamps in and rate results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface frm_in_if;
  logic                       valid;
  logic                       ready;
  logic [frm_pkg::TS_W-1:0]   timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

interface frm_out_if;
  logic                       valid;
  logic                       ready;
  logic [frm_pkg::RATE_W-1:0] rate_q8;
  logic                       no_rate;
  logic [frm_pkg::EVT_W-1:0]  event_count;

  modport source (output valid, output rate_q8, output no_rate, output event_count,
                  input ready);
  modport sink   (input valid, input rate_q8, input no_rate, input event_count,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/frm_regs.sv
// ----------------------------------------------------------------------------
// frm_regs
// APB-style register file holding the tick frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [frm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [frm_pkg::DATA_W-1:0]  pwdata,
  output logic      [frm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [frm_pkg::DATA_W-1:0]  tick_freq
);

  logic [frm_pkg::DATA_W-1:0] freq_r;
  logic [frm_pkg::DATA_W-1:0] freq_nxt;
  logic [frm_pkg::IDX_W-1:0]  reg_idx;
  logic                       wr_en;

  assign reg_idx = paddr[frm_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the tick frequency on a completed write transaction
  always_comb begin
    freq_nxt = freq_r;
    if (wr_en && (reg_idx == frm_pkg::REG_TICK_FREQ)) begin
      freq_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= frm_pkg::FREQ_RESET;
    end else begin
      freq_r <= freq_nxt;
    end
  end

  // Read back; unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (reg_idx == frm_pkg::REG_TICK_FREQ) begin
      prdata = freq_r;
    end
  end

  assign tick_freq = freq_r;

endmodule

`default_nettype wire

FILE: rtl/core/frm_ctrl.sv
// ----------------------------------------------------------------------------
// frm_ctrl
// Sequencer for one frame event: interval, ring update, divide, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output frm_pkg::ctrl_cmd_t      cmd,
  input  wire frm_pkg::ctrl_sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIFF = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/frm_datapath.sv
// ----------------------------------------------------------------------------
// frm_datapath
// Interval ring, running sum, event count, numerator multiply and a
// restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_datapath #(
  parameter int WINDOW = frm_pkg::WINDOW_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire frm_pkg::ctrl_cmd_t          cmd,
  output frm_pkg::ctrl_sts_t               sts,
  input  wire logic [frm_pkg::DATA_W-1:0]  tick_freq,
  input  wire logic [frm_pkg::TS_W-1:0]    timestamp,
  output logic      [frm_pkg::RATE_W-1:0]  rate_q8,
  output logic                             no_rate,
  output logic      [frm_pkg::EVT_W-1:0]   event_count
);

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = frm_pkg::IV_W + PTR_W;
  localparam int PROD_W = frm_pkg::DATA_W + CNT_W;
  localparam int NUM_W  = PROD_W + frm_pkg::FRAC_W;
  localparam int DCNT_W = $clog2(NUM_W);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(WINDOW);
  localparam logic [DCNT_W-1:0] DCNT_INIT = DCNT_W'(NUM_W - 1);

  // Interval ring
  logic [frm_pkg::IV_W-1:0] ring_mem [WINDOW];
  logic [frm_pkg::IV_W-1:0] ring_rd_r;
  logic                     ring_we;

  // Event state
  logic [frm_pkg::TS_W-1:0] ts_r;
  logic [frm_pkg::TS_W-1:0] last_ts_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     first_r;
  logic [PTR_W-1:0]         ptr_r;
  logic                     wrapped_r;
  logic [SUM_W-1:0]         sum_r;
  logic [frm_pkg::IV_W-1:0] diff_r;
  logic [NUM_W-1:0]         num_r;

  // Divider
  logic [SUM_W-1:0]         rem_r;
  logic [NUM_W-1:0]         quo_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic [SUM_W:0]           trial;
  logic                     trial_ge;

  // Output register
  logic [frm_pkg::RATE_W-1:0] rate_out_r;
  logic                       no_rate_out_r;
  logic [frm_pkg::EVT_W-1:0]  evt_out_r;

  logic [frm_pkg::TS_W-1:0]   ts_delta;
  logic [frm_pkg::IV_W-1:0]   old_iv;
  logic [PROD_W-1:0]          prod;
  logic [frm_pkg::RATE_W-1:0] rate_sat;

  // Read the ring every cycle; written only on a non-first event
  assign ring_we = cmd.sum && !first_r;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ptr_r] <= diff_r;
    end
    ring_rd_r <= ring_mem[ptr_r];
  end

  // Entries ahead of the first wrap were never written: treat as zero
  assign old_iv = wrapped_r ? ring_rd_r : '0;

  // Interval modulo 2^63, saturated to 32 bits
  assign ts_delta = ts_r - last_ts_r;
  assign prod     = PROD_W'(tick_freq) * PROD_W'(cnt_r);

  // Control state: count, pointer, wrap flag, sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      first_r   <= 1'b0;
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
      last_ts_r <= '0;
      dcnt_r    <= '0;
    end else begin
      if (cmd.accept) begin
        first_r <= (cnt_r == '0);
        if (cnt_r < CNT_MAX) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.sum) begin
        last_ts_r <= ts_r;
        if (!first_r) begin
          sum_r <= sum_r - SUM_W'(old_iv) + SUM_W'(diff_r);
          if (ptr_r == PTR_LAST) begin
            ptr_r     <= '0;
            wrapped_r <= 1'b1;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        dcnt_r <= DCNT_INIT;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 1'b1;
      end
    end
  end

  // Payload: timestamp, interval, numerator
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ts_r <= timestamp;
    end
    if (cmd.diff) begin
      diff_r <= (|ts_delta[frm_pkg::TS_W-1:frm_pkg::IV_W]) ? '1
                                                            : ts_delta[frm_pkg::IV_W-1:0];
      num_r  <= {prod, {frm_pkg::FRAC_W{1'b0}}};
    end
  end

  // Restoring divide step against the running sum
  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, sum_r});

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rem_r <= '0;
      quo_r <= num_r;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? SUM_W'(trial - {1'b0, sum_r}) : trial[SUM_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], trial_ge};
    end
  end

  assign sts.div_done = (dcnt_r == '0);

  // Saturate the quotient to the rate width
  assign rate_sat = (|quo_r[NUM_W-1:frm_pkg::RATE_W]) ? '1 : quo_r[frm_pkg::RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      no_rate_out_r <= (sum_r == '0);
      rate_out_r    <= (sum_r == '0) ? '0 : rate_sat;
      evt_out_r     <= frm_pkg::EVT_W'(cnt_r);
    end
  end

  assign rate_q8     = rate_out_r;
  assign no_rate     = no_rate_out_r;
  assign event_count = evt_out_r;

endmodule

`default_nettype wire

FILE: rtl/core/frame_rate_window_meter.sv
// ----------------------------------------------------------------------------
// frame_rate_window_meter
// Moving-average frame rate meter over the last WINDOW frame intervals.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one free-running timestamp per frame event; out_ch returns
//   one result per event: rate_q8 (frames/s, 8 fraction bits, truncated and
//   saturating), no_rate (interval sum is zero) and event_count (saturating
//   at WINDOW). The APB-style port holds tick_frequency at byte address 0.
// Sequencing:
//   One event at a time. After the accepting edge the event passes through
//   the diff, sum and divide states; the restoring divider produces one
//   quotient bit per cycle of a NUM_W = 40 + clog2(WINDOW+1) bit quotient.
//   The next event is accepted the cycle after the result is loaded.
// Reset:
//   Synchronous active-low rst_n clears count, pointer, sum and last
//   timestamp and sets tick_frequency to 1000000. The ring needs no clearing
//   pass: entries not yet reached since reset read as zero via a wrap flag.
// Stall:
//   A result waits in the output register while out_ch.ready is low; one
//   further event is accepted and processed, then holds until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rate_window_meter #(
  parameter int WINDOW = frm_pkg::WINDOW_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  frm_in_if.sink                           in_ch,
  frm_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [frm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [frm_pkg::DATA_W-1:0]  pwdata,
  output logic      [frm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  frm_pkg::ctrl_cmd_t         cmd;
  frm_pkg::ctrl_sts_t         sts;
  logic [frm_pkg::DATA_W-1:0] tick_freq;
  logic                       in_ready;
  logic                       out_valid;

  // Configuration registers
  frm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tick_freq (tick_freq)
  );

  // Event sequencer
  frm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Ring, sum and divider
  frm_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .tick_freq   (tick_freq),
    .timestamp   (in_ch.timestamp),
    .rate_q8     (out_ch.rate_q8),
    .no_rate     (out_ch.no_rate),
    .event_count (out_ch.event_count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

FILE: dv/frame_rate_window_meter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_rate_window_meter_test
// Self-checking testbench for the moving-average frame rate meter. Frame
// timestamps go in on a valid/ready channel and rate results are scored
// against an in-bench model of the interval ring, its running sum and the
// Q8 rate division. tick_frequency is written over the APB-style port
// between phases.
// ----------------------------------------------------------------------------

module frame_rate_window_meter_test;

  localparam int          WIN        = 100;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int          DRAIN_WAIT = 60;

  localparam logic [frm_pkg::ADDR_W-1:0] ADDR_TICK_FREQ = {frm_pkg::REG_TICK_FREQ, 2'b00};
  localparam logic [frm_pkg::IDX_W-1:0]  REG_SPARE      = frm_pkg::REG_TICK_FREQ + 1'b1;
  localparam logic [frm_pkg::ADDR_W-1:0] ADDR_SPARE     = {REG_SPARE, 2'b00};
  localparam logic [63:0]                IV_CEIL        = 64'hFFFF_FFFF;
  localparam logic [63:0]                RATE_CEIL      = (64'd1 << frm_pkg::RATE_W) - 64'd1;
  localparam logic [frm_pkg::TS_W-1:0]   TS_TOP         = '1;

  typedef struct packed {
    logic [frm_pkg::RATE_W-1:0] rate_q8;
    logic                       no_rate;
    logic [frm_pkg::EVT_W-1:0]  event_count;
  } rate_result_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [frm_pkg::ADDR_W-1:0] paddr;
  logic [frm_pkg::DATA_W-1:0] pwdata;
  logic [frm_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  frm_in_if  frame_ts ();
  frm_out_if frame_rate ();

  frame_rate_window_meter #(.WINDOW(WIN)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (frame_ts),
    .out_ch  (frame_rate),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Rate model state
  logic [frm_pkg::DATA_W-1:0] tick_freq;
  logic [frm_pkg::TS_W-1:0]   prev_ts;
  logic [frm_pkg::IV_W-1:0]   iv_ring [WIN];
  logic [41:0]                iv_sum;
  int                         ring_idx;
  int                         evt_seen;

  rate_result_t               pending_rates[$];
  logic [frm_pkg::TS_W-1:0]   last_sent_ts;
  int unsigned                mismatch_count;
  int unsigned                cycle_count;
  int unsigned                long_hold_left;
  bit                         gap_en;
  bit                         stall_en;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("** frame_rate_window_meter: FAILED **");
      $finish;
    end
  end

  // Compute the next rate result and advance the window state
  function automatic rate_result_t predict_rate(input logic [frm_pkg::TS_W-1:0] ts);
    rate_result_t              res;
    logic [frm_pkg::TS_W-1:0]  gap;
    logic [frm_pkg::IV_W-1:0]  iv;
    logic [63:0]               numer;
    logic [63:0]               quot;
    if (evt_seen < WIN) evt_seen++;
    if (evt_seen == 1) begin
      prev_ts = ts;
    end else begin
      gap = ts - prev_ts;
      iv = (64'(gap) > IV_CEIL) ? '1 : gap[frm_pkg::IV_W-1:0];
      prev_ts = ts;
      iv_sum = iv_sum - 42'(iv_ring[ring_idx]) + 42'(iv);
      iv_ring[ring_idx] = iv;
      ring_idx = (ring_idx == WIN - 1) ? 0 : ring_idx + 1;
    end
    res.event_count = frm_pkg::EVT_W'(evt_seen);
    if (iv_sum == '0) begin
      res.rate_q8 = '0;
      res.no_rate = 1'b1;
    end else begin
      numer = (64'(tick_freq) * 64'(evt_seen)) << frm_pkg::FRAC_W;
      quot = numer / 64'(iv_sum);
      res.rate_q8 = (quot > RATE_CEIL) ? '1 : quot[frm_pkg::RATE_W-1:0];
      res.no_rate = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Score each result transaction against the oldest prediction
  always @(posedge clk) begin
    rate_result_t want;
    if (rst_n && frame_rate.valid && frame_rate.ready) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("result with no pending frame", 64'd0, 64'(frame_rate.rate_q8));
      end else begin
        want = pending_rates.pop_front();
        if (frame_rate.rate_q8 !== want.rate_q8)
          report_mismatch("rate_q8", 64'(want.rate_q8), 64'(frame_rate.rate_q8));
        if (frame_rate.no_rate !== want.no_rate)
          report_mismatch("no_rate", 64'(want.no_rate), 64'(frame_rate.no_rate));
        if (frame_rate.event_count !== want.event_count)
          report_mismatch("event_count", 64'(want.event_count),
                          64'(frame_rate.event_count));
      end
    end
  end

  // Drive result ready: long hold-offs, random stall bursts, else ready
  initial begin
    frame_rate.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_left > 0) begin
        frame_rate.ready <= 1'b0;
        long_hold_left--;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        frame_rate.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        frame_rate.ready <= 1'b1;
      end
    end
  end

  // Offer one timestamp, predict its result once the transaction completes
  task automatic send_frame(input logic [frm_pkg::TS_W-1:0] ts);
    @(negedge clk);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      frame_ts.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    frame_ts.valid     <= 1'b1;
    frame_ts.timestamp <= ts;
    do @(posedge clk); while (!frame_ts.ready);
    pending_rates.push_back(predict_rate(ts));
    last_sent_ts = ts;
  endtask

  task automatic lower_valid();
    @(negedge clk);
    frame_ts.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_rates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [frm_pkg::ADDR_W-1:0] addr,
                           input logic [frm_pkg::DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[frm_pkg::ADDR_W-1:2] == frm_pkg::REG_TICK_FREQ) tick_freq = data;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_tick_freq();
    logic [frm_pkg::DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TICK_FREQ;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== tick_freq) report_mismatch("tick_frequency read", 64'(tick_freq), 64'(got));
  endtask

  // Next timestamp: mostly steady frame spacing, sometimes odd jumps
  function automatic logic [frm_pkg::TS_W-1:0] pick_timestamp(input int unsigned max_step);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return last_sent_ts + frm_pkg::TS_W'($urandom_range(1, max_step));
    if (sel < 80) return last_sent_ts + frm_pkg::TS_W'($urandom_range(0, 3));
    if (sel < 85)
      return last_sent_ts + frm_pkg::TS_W'(64'h1_0000_0000) + frm_pkg::TS_W'($urandom);
    if (sel < 90) return last_sent_ts - frm_pkg::TS_W'($urandom_range(1, 1000));
    if (sel < 95) return last_sent_ts + frm_pkg::TS_W'($urandom);
    return frm_pkg::TS_W'({$urandom, $urandom});
  endfunction

  task automatic run_frame_burst(input int count, input int unsigned max_step);
    repeat (count) send_frame(pick_timestamp(max_step));
    lower_valid();
  endtask

  // Reset value, and a write to an unmapped register leaves tick_frequency alone
  task automatic test_register_map();
    check_tick_freq();
    write_reg(ADDR_SPARE, 32'hDEAD_BEEF);
    check_tick_freq();
  endtask

  // First event, zero intervals, rate saturation, zero tick frequency
  task automatic test_first_events();
    write_reg(ADDR_TICK_FREQ, '1);
    check_tick_freq();
    send_frame('0);
    send_frame('0);
    send_frame(frm_pkg::TS_W'(1));
    send_frame(frm_pkg::TS_W'(1));
    lower_valid();
    wait_drained();
    write_reg(ADDR_TICK_FREQ, '0);
    send_frame(frm_pkg::TS_W'(2));
    send_frame(frm_pkg::TS_W'(3));
    lower_valid();
    wait_drained();
    write_reg(ADDR_TICK_FREQ, frm_pkg::FREQ_RESET);
    check_tick_freq();
  endtask

  // Long intervals, backward and wrapping timestamps, alternating bit patterns
  task automatic test_timestamp_extremes();
    send_frame(frm_pkg::TS_W'(1000));
    send_frame(frm_pkg::TS_W'(1000) + frm_pkg::TS_W'(64'h1_0000_0007));
    send_frame(TS_TOP);
    send_frame(frm_pkg::TS_W'(4));
    send_frame(frm_pkg::TS_W'(3));
    send_frame(frm_pkg::TS_W'(64'h5555_5555_5555_5555));
    send_frame(frm_pkg::TS_W'(64'h2AAA_AAAA_AAAA_AAAA));
    send_frame(frm_pkg::TS_W'(64'h2AAA_AAAA_AAAA_AAAA) + frm_pkg::TS_W'(100));
    lower_valid();
    wait_drained();
  endtask

  // Random frame streams under several tick frequencies
  task automatic test_random_frames();
    logic [frm_pkg::DATA_W-1:0] freqs [6];
    int unsigned                steps [6];
    freqs = '{32'd1, 32'd60, frm_pkg::FREQ_RESET, 32'hFFFF_FFFF, $urandom, 32'd27_000_000};
    steps = '{8, 1000, 40_000, 1 << 20, $urandom_range(1, 1 << 24), 450_000};
    foreach (freqs[i]) begin
      wait_drained();
      write_reg(ADDR_TICK_FREQ, freqs[i]);
      run_frame_burst(240, steps[i]);
    end
    wait_drained();
  endtask

  // Hold off results long enough to stall input, then pause until drained
  task automatic test_output_backpressure();
    long_hold_left = 400;
    run_frame_burst(12, 20_000);
    wait_drained();
    run_frame_burst(30, 20_000);
    wait_drained();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_streaming_no_idle();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    write_reg(ADDR_TICK_FREQ, 32'd90_000);
    run_frame_burst(300, 5000);
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    frame_ts.valid     = 1'b0;
    frame_ts.timestamp = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    tick_freq          = frm_pkg::FREQ_RESET;
    prev_ts            = '0;
    iv_sum             = '0;
    ring_idx           = 0;
    evt_seen           = 0;
    last_sent_ts       = '0;
    mismatch_count     = 0;
    cycle_count        = 0;
    long_hold_left     = 0;
    gap_en             = 1'b1;
    stall_en           = 1'b1;
    foreach (iv_ring[i]) iv_ring[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_map();
    test_first_events();
    test_timestamp_extremes();
    test_random_frames();
    test_output_backpressure();
    test_streaming_no_idle();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_rates.size() == 0) begin
      $display("** frame_rate_window_meter: PASSED **");
    end else begin
      $display("** frame_rate_window_meter: FAILED **");
    end
    $finish;
  end

endmodule
